@@ hw/rtl/scalar_kalman_vector_obs_top_assert.svh @@
// Assertion macros for the scalar Kalman filter top level.
`ifndef SCALAR_KALMAN_VECTOR_OBS_TOP_ASSERT_SVH
`define SCALAR_KALMAN_VECTOR_OBS_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
`define SKVO_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("skvo assertion failed");
`define SKVO_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("skvo assertion failed");
`else
`define SKVO_ASSERT_IMP(lbl, ante, cons)
`define SKVO_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

@@ hw/rtl/skvo_pkg.sv @@
// Shared types and constants of the scalar Kalman filter.
package skvo_pkg;

  localparam int unsigned NOBS_DEF = 4;
  localparam int unsigned MAX_OBS = 4;
  localparam int unsigned OBS_IW = 2;
  localparam int unsigned CFG_IW = 3;
  localparam int unsigned CNT_W = 3;

  localparam int unsigned MUL_AW = 50;
  localparam int unsigned MUL_BW = 17;
  localparam int unsigned MUL_PW = MUL_AW + MUL_BW;
  localparam int unsigned MUL_BWORD = 3 * MUL_BW;
  localparam int unsigned ACC_W = MUL_AW + MUL_BWORD;
  localparam logic [CNT_W-1:0] ND_SHORT = 3'd2;
  localparam logic [CNT_W-1:0] ND_LONG = 3'd3;

  localparam int unsigned DIV_NW = 48;
  localparam int unsigned DIV_DW = 50;
  localparam int unsigned DIV_CW = 6;

  localparam logic [31:0] ONE_Q16 = 32'h0001_0000;
  localparam logic [40:0] DX_CAP = {1'b1, 40'b0};

  typedef enum logic [CFG_IW-1:0] {
    REG_PROCESS_STD   = 3'd0,
    REG_INIT_ESTIMATE = 3'd1,
    REG_INIT_VARIANCE = 3'd2,
    REG_WEIGHT_0      = 3'd3,
    REG_WEIGHT_1      = 3'd4,
    REG_WEIGHT_2      = 3'd5,
    REG_WEIGHT_3      = 3'd6
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DMUL,
    ST_DIV,
    ST_XMUL
  } state_t;

  typedef struct packed {
    logic signed [31:0] obs_0;
    logic signed [31:0] obs_1;
    logic signed [31:0] obs_2;
    logic signed [31:0] obs_3;
  } in_data_t;

  typedef struct packed {
    logic signed [31:0] estimate;
    logic [31:0]        variance;
  } out_data_t;

  typedef struct packed {
    logic issue;
    logic first;
  } mac_ctl_t;

endpackage

@@ hw/rtl/skvo_mac.sv @@
// Shared digit-serial multiply-accumulate unit, one 17-bit digit per cycle.
module skvo_mac (
  input  logic                             clk,
  input  logic                             rst_n,
  input  skvo_pkg::mac_ctl_t               ctl,
  input  logic [skvo_pkg::MUL_AW-1:0]      a,
  input  logic [skvo_pkg::MUL_BW-1:0]      b,
  output logic [skvo_pkg::ACC_W-1:0]       acc
);

  logic [skvo_pkg::MUL_PW-1:0] prod_r;
  logic                        vld_r;
  logic                        first_r;
  logic [skvo_pkg::ACC_W-1:0]  acc_r;
  logic [skvo_pkg::ACC_W-1:0]  acc_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= 1'b0;
      first_r <= 1'b0;
    end else begin
      vld_r   <= ctl.issue;
      first_r <= ctl.first;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.issue) begin
      prod_r <= a * b;
    end
    if (vld_r) begin
      acc_r <= acc_nxt;
    end
  end

  always_comb begin
    if (first_r) begin
      acc_nxt = skvo_pkg::ACC_W'(prod_r);
    end else begin
      acc_nxt = {acc_r[skvo_pkg::ACC_W-skvo_pkg::MUL_BW-1:0], skvo_pkg::MUL_BW'(0)}
                + skvo_pkg::ACC_W'(prod_r);
    end
  end

  assign acc = acc_r;

endmodule

@@ hw/rtl/skvo_div.sv @@
// Radix-2 restoring divider, one quotient bit per cycle.
module skvo_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [skvo_pkg::DIV_NW-1:0]   dividend,
  input  logic [skvo_pkg::DIV_DW-1:0]   divisor,
  output logic                          done,
  output logic [skvo_pkg::DIV_NW-1:0]   quot
);

  logic                          busy_r;
  logic                          done_r;
  logic [skvo_pkg::DIV_CW-1:0]   cnt_r;
  logic [skvo_pkg::DIV_DW-1:0]   rem_r;
  logic [skvo_pkg::DIV_NW-1:0]   quo_r;
  logic [skvo_pkg::DIV_DW-1:0]   den_r;
  logic [skvo_pkg::DIV_DW:0]     trial;
  logic [skvo_pkg::DIV_DW:0]     diff;
  logic                          ge;

  assign trial = {rem_r, quo_r[skvo_pkg::DIV_NW-1]};
  assign diff  = trial - {1'b0, den_r};
  assign ge    = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == skvo_pkg::DIV_CW'(skvo_pkg::DIV_NW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      den_r <= divisor;
    end else if (busy_r) begin
      rem_r <= ge ? diff[skvo_pkg::DIV_DW-1:0] : trial[skvo_pkg::DIV_DW-1:0];
      quo_r <= {quo_r[skvo_pkg::DIV_NW-2:0], ge};
    end
  end

  assign done = done_r;
  assign quot = quo_r;

endmodule

@@ hw/rtl/scalar_kalman_vector_obs_top.sv @@
// Top level of the scalar random-walk Kalman filter with a vector observation.
//
//   channel  direction  handshake               payload
//   in       input      in_valid / in_ready     in_data  (obs_0 .. obs_3)
//   out      output     out_valid / out_ready   out_data (estimate, variance)
//   cfg      input      cfg_we                  cfg_index, cfg_wdata
//
// From acceptance to result, a beat passes through p*W on the shared multiplier, 48 steps
// of the radix-2 divider for p/d (the innovation terms and the process variance are
// formed on the multiplier meanwhile), and the estimate correction. Reset is synchronous
// and needs no clearing pass. A result waits in the output register while the next beat
// is accepted; the block holds its last step only when the output
// register is still full.
`include "scalar_kalman_vector_obs_top_assert.svh"

module scalar_kalman_vector_obs_top #(
  parameter int unsigned NOBS = skvo_pkg::NOBS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  skvo_pkg::in_data_t            in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output skvo_pkg::out_data_t           out_data,
  input  logic                          cfg_we,
  input  logic [skvo_pkg::CFG_IW-1:0]   cfg_index,
  input  logic [31:0]                   cfg_wdata
);

  skvo_pkg::state_t              state_r;
  skvo_pkg::state_t              state_nxt;
  logic [skvo_pkg::CNT_W-1:0]    cnt_r;
  logic [skvo_pkg::OBS_IW-1:0]   job_r;
  logic                          sq_ph_r;
  logic                          work_done_r;
  logic                          div_done_r;

  logic signed [31:0]            obs_r [skvo_pkg::MAX_OBS];
  logic signed [31:0]            w_r [skvo_pkg::MAX_OBS];
  logic signed [31:0]            x_r;
  logic [31:0]                   p_r;
  logic [31:0]                   std_r;
  logic signed [51:0]            s_r;
  logic [47:0]                   s2_r;
  logic [47:0]                   q_r;
  skvo_pkg::out_data_t           out_r;
  logic                          out_valid_r;

  skvo_pkg::mac_ctl_t            mac_ctl;
  logic [skvo_pkg::MUL_AW-1:0]   mac_a;
  logic [skvo_pkg::MUL_BW-1:0]   mac_b;
  logic [skvo_pkg::MUL_BWORD-1:0] b_word;
  logic [skvo_pkg::CNT_W-1:0]    ndig;
  logic [1:0]                    dsel;
  logic [skvo_pkg::ACC_W-1:0]    acc;
  logic                          last;
  logic                          accept;
  logic                          finish;

  logic                          div_start;
  logic                          div_done;
  logic [skvo_pkg::DIV_NW-1:0]   div_quot;
  logic [skvo_pkg::DIV_DW-1:0]   divisor;

  logic signed [34:0]            wsum;
  logic [34:0]                   wsum_abs;
  logic signed [32:0]            err;
  logic [32:0]                   err_abs;
  logic signed [31:0]            w_sel;
  logic [32:0]                   w_abs;
  logic [49:0]                   s_abs;
  logic [49:0]                   dmag;
  logic signed [51:0]            dterm;
  logic signed [51:0]            dval;
  logic [47:0]                   tmag;
  logic signed [51:0]            sterm;
  logic [84:0]                   xt;
  logic [40:0]                   xcap;
  logic signed [42:0]            dx;
  logic signed [42:0]            xsum;
  logic signed [31:0]            x_new;
  logic [31:0]                   pv;
  logic [48:0]                   psum;
  logic [31:0]                   p_new;

  assign accept = in_valid && in_ready;
  assign last   = cnt_r == ndig + 3'd1;
  assign finish = (state_r == skvo_pkg::ST_XMUL) && last && (!out_valid_r || out_ready);

  always_comb begin
    wsum = '0;
    for (int i = 0; i < skvo_pkg::MAX_OBS; i++) begin
      if (i < NOBS) begin
        wsum = wsum + 35'(w_r[i]);
      end
    end
  end

  assign wsum_abs = wsum[34] ? 35'(-wsum) : 35'(wsum);
  assign err      = 33'(obs_r[job_r]) - 33'(x_r);
  assign err_abs  = err[32] ? 33'(-err) : 33'(err);
  assign w_sel    = w_r[job_r];
  assign w_abs    = w_sel[31] ? 33'(-33'(w_sel)) : 33'(w_sel);
  assign s_abs    = s_r[51] ? 50'(-s_r) : s_r[49:0];

  assign dmag     = acc[65:16];
  assign dterm    = wsum[34] ? -$signed({2'b0, dmag}) : $signed({2'b0, dmag});
  assign dval     = $signed({20'b0, skvo_pkg::ONE_Q16}) + dterm;
  assign divisor  = (dval <= 52'sd0) ? 50'd1 : dval[49:0];

  assign tmag     = acc[63:16];
  assign sterm    = (w_sel[31] ^ err[32]) ? -$signed({4'b0, tmag}) : $signed({4'b0, tmag});

  assign xt       = acc[100:16];
  assign xcap     = (xt > 85'(skvo_pkg::DX_CAP)) ? skvo_pkg::DX_CAP : xt[40:0];
  assign dx       = s_r[51] ? -$signed({2'b0, xcap}) : $signed({2'b0, xcap});
  assign xsum     = 43'(x_r) + dx;

  always_comb begin
    if (xsum > 43'sd2147483647) begin
      x_new = 32'sh7FFF_FFFF;
    end else if (xsum < -43'sd2147483648) begin
      x_new = 32'sh8000_0000;
    end else begin
      x_new = xsum[31:0];
    end
  end

  assign pv    = (|q_r[47:32]) ? 32'hFFFF_FFFF : q_r[31:0];
  assign psum  = 49'(pv) + 49'(s2_r);
  assign p_new = (|psum[48:32]) ? 32'hFFFF_FFFF : psum[31:0];

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      skvo_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = skvo_pkg::ST_DMUL;
        end
      end
      skvo_pkg::ST_DMUL: begin
        if (last) begin
          state_nxt = skvo_pkg::ST_DIV;
        end
      end
      skvo_pkg::ST_DIV: begin
        if (div_done_r && work_done_r) begin
          state_nxt = skvo_pkg::ST_XMUL;
        end
      end
      skvo_pkg::ST_XMUL: begin
        if (finish) begin
          state_nxt = skvo_pkg::ST_IDLE;
        end
      end
      default: state_nxt = skvo_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    mac_a     = '0;
    b_word    = '0;
    ndig      = skvo_pkg::ND_SHORT;
    mac_ctl   = '0;
    div_start = 1'b0;
    case (state_r)
      skvo_pkg::ST_DMUL: begin
        mac_a         = skvo_pkg::MUL_AW'(wsum_abs);
        b_word        = skvo_pkg::MUL_BWORD'(p_r);
        mac_ctl.issue = cnt_r < ndig;
        div_start     = last;
      end
      skvo_pkg::ST_DIV: begin
        if (sq_ph_r) begin
          mac_a  = skvo_pkg::MUL_AW'(std_r);
          b_word = skvo_pkg::MUL_BWORD'(std_r);
        end else begin
          mac_a  = skvo_pkg::MUL_AW'(err_abs);
          b_word = skvo_pkg::MUL_BWORD'(w_abs);
        end
        mac_ctl.issue = !work_done_r && (cnt_r < ndig);
      end
      skvo_pkg::ST_XMUL: begin
        ndig          = skvo_pkg::ND_LONG;
        mac_a         = s_abs;
        b_word        = skvo_pkg::MUL_BWORD'(q_r);
        mac_ctl.issue = cnt_r < ndig;
      end
      default: begin
        mac_a = '0;
      end
    endcase
    mac_ctl.first = cnt_r == '0;
  end

  assign dsel = 2'(ndig - 3'd1 - cnt_r);

  always_comb begin
    case (dsel)
      2'd0:    mac_b = b_word[16:0];
      2'd1:    mac_b = b_word[33:17];
      2'd2:    mac_b = b_word[50:34];
      default: mac_b = '0;
    endcase
  end

  skvo_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (mac_ctl),
    .a     (mac_a),
    .b     (mac_b),
    .acc   (acc)
  );

  skvo_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend ({p_r, 16'b0}),
    .divisor  (divisor),
    .done     (div_done),
    .quot     (div_quot)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= skvo_pkg::ST_IDLE;
      cnt_r       <= '0;
      job_r       <= '0;
      sq_ph_r     <= 1'b0;
      work_done_r <= 1'b0;
      div_done_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        skvo_pkg::ST_IDLE: begin
          cnt_r <= '0;
          if (accept) begin
            job_r       <= '0;
            sq_ph_r     <= 1'b0;
            work_done_r <= 1'b0;
            div_done_r  <= 1'b0;
          end
        end
        skvo_pkg::ST_DMUL: begin
          cnt_r <= last ? '0 : cnt_r + 1'b1;
        end
        skvo_pkg::ST_DIV: begin
          if (!work_done_r) begin
            cnt_r <= last ? '0 : cnt_r + 1'b1;
            if (last) begin
              if (sq_ph_r) begin
                work_done_r <= 1'b1;
              end else if (job_r == skvo_pkg::OBS_IW'(NOBS - 1)) begin
                sq_ph_r <= 1'b1;
              end else begin
                job_r <= job_r + 1'b1;
              end
            end
          end
          if (div_done) begin
            div_done_r <= 1'b1;
          end
        end
        skvo_pkg::ST_XMUL: begin
          if (!last) begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        default: cnt_r <= '0;
      endcase
      if (finish) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      obs_r[0] <= in_data.obs_0;
      obs_r[1] <= in_data.obs_1;
      obs_r[2] <= in_data.obs_2;
      obs_r[3] <= in_data.obs_3;
      s_r      <= '0;
    end else if (state_r == skvo_pkg::ST_DIV && !work_done_r && last && !sq_ph_r) begin
      s_r <= s_r + sterm;
    end
    if (state_r == skvo_pkg::ST_DIV && !work_done_r && last && sq_ph_r) begin
      s2_r <= acc[63:16];
    end
    if (div_done) begin
      q_r <= div_quot;
    end
    if (finish) begin
      out_r.estimate <= x_new;
      out_r.variance <= pv;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      std_r <= '0;
      x_r   <= '0;
      p_r   <= skvo_pkg::ONE_Q16;
      for (int i = 0; i < skvo_pkg::MAX_OBS; i++) begin
        w_r[i] <= skvo_pkg::ONE_Q16;
      end
    end else if (finish) begin
      x_r <= x_new;
      p_r <= p_new;
    end else if (cfg_we) begin
      case (cfg_index)
        skvo_pkg::REG_PROCESS_STD:   std_r  <= cfg_wdata;
        skvo_pkg::REG_INIT_ESTIMATE: x_r    <= cfg_wdata;
        skvo_pkg::REG_INIT_VARIANCE: p_r    <= cfg_wdata;
        skvo_pkg::REG_WEIGHT_0:      w_r[0] <= cfg_wdata;
        skvo_pkg::REG_WEIGHT_1:      w_r[1] <= cfg_wdata;
        skvo_pkg::REG_WEIGHT_2:      w_r[2] <= cfg_wdata;
        skvo_pkg::REG_WEIGHT_3:      w_r[3] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign in_ready  = state_r == skvo_pkg::ST_IDLE;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `SKVO_ASSERT_NEXT(a_accept_starts, in_valid && in_ready, state_r == skvo_pkg::ST_DMUL)
  `SKVO_ASSERT_IMP(a_div_done_in_div, div_done, state_r == skvo_pkg::ST_DIV)
  `SKVO_ASSERT_IMP(a_xmul_after_div, state_r == skvo_pkg::ST_XMUL, div_done_r && work_done_r)

endmodule
